>>> src/es2y_pkg.sv
// ----------------------------------------------------------------------------
// es2y_pkg
// Shared types and fixed constants for the epoch seconds to calendar converter.
// ----------------------------------------------------------------------------
package es2y_pkg;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DAY_LO,
        S_DAY_HI,
        S_TOD,
        S_HOUR_Q,
        S_HOUR_R,
        S_MIN_Q,
        S_MIN_R,
        S_YEAR
    } t_state;

    localparam int unsigned SECS_PER_DAY  = 86400;
    localparam int unsigned SECS_PER_HOUR = 3600;
    localparam int unsigned SECS_PER_MIN  = 60;

    // Bits of a remainder of each division
    localparam int unsigned TOD_W  = 17;   // seconds of the day
    localparam int unsigned HREM_W = 12;   // seconds of the hour

    // Second operand width of the shared multiplier
    localparam int unsigned MUL_B_W = 17;

    // 86400 = 675 << 7; 675 needs 10 bits of reciprocal headroom
    localparam int unsigned DAY_SHIFT   = 7;
    localparam int unsigned DAY_DIV     = 675;
    localparam int unsigned DAY_DIV_LOG = 10;

    // 3600 = 225 << 4: hour = ((tod >> 4) * 9321) >> 21, exact for tod < 86400
    localparam int unsigned HOUR_PRE_SH   = 4;
    localparam int unsigned HOUR_RECIP    = 9321;
    localparam int unsigned HOUR_RECIP_SH = 21;

    // 60 = 15 << 2: minute = ((rem >> 2) * 1093) >> 14, exact for rem < 3600
    localparam int unsigned MIN_PRE_SH   = 2;
    localparam int unsigned MIN_RECIP    = 1093;
    localparam int unsigned MIN_RECIP_SH = 14;

    localparam int unsigned YEAR_W = 12;
    localparam int unsigned DOY_W  = 9;

    localparam logic [YEAR_W-1:0] BASE_YEAR = 12'd1970;
    // 1970 mod 4, mod 100, and its century (19) mod 4
    localparam logic [1:0] BASE_MOD4    = 2'd2;
    localparam logic [6:0] BASE_MOD100  = 7'd70;
    localparam logic [1:0] BASE_CENT4   = 2'd3;
    localparam logic [6:0] LAST_MOD100  = 7'd99;

    localparam logic [DOY_W-1:0] DAYS_COMMON = 9'd365;
    localparam logic [DOY_W-1:0] DAYS_LEAP   = 9'd366;

endpackage

>>> src/es2y_cmpsub.sv
// ----------------------------------------------------------------------------
// es2y_cmpsub
// Compare-and-subtract unit used by the year walk.
// ----------------------------------------------------------------------------
module es2y_cmpsub #(
    parameter int unsigned WIDTH = 18
) (
    input  logic [WIDTH-1:0] i_a,
    input  logic [WIDTH-1:0] i_b,
    output logic [WIDTH-1:0] o_diff,
    output logic             o_ge
);

    logic [WIDTH:0] w_diff;

    // Borrow out of the extended subtract flags a < b
    assign w_diff = {1'b0, i_a} - {1'b0, i_b};
    assign o_diff = w_diff[WIDTH-1:0];
    assign o_ge   = ~w_diff[WIDTH];

endmodule

>>> src/es2y_year.sv
// ----------------------------------------------------------------------------
// es2y_year
// Year counter with running mod-4/100/400 tracking for the leap rule.
// ----------------------------------------------------------------------------
module es2y_year (
    input  logic                           i_clk,
    input  logic                           i_load,
    input  logic                           i_step,
    output logic [es2y_pkg::YEAR_W-1:0]    o_year,
    output logic [es2y_pkg::DOY_W-1:0]     o_year_len
);

    logic [es2y_pkg::YEAR_W-1:0] r_year, n_year;
    logic [1:0]                  r_mod4, n_mod4;
    logic [6:0]                  r_mod100, n_mod100;
    logic [1:0]                  r_cent4, n_cent4;
    logic                        w_leap;

    always_comb begin
        n_year   = r_year;
        n_mod4   = r_mod4;
        n_mod100 = r_mod100;
        n_cent4  = r_cent4;
        if (i_load) begin
            n_year   = es2y_pkg::BASE_YEAR;
            n_mod4   = es2y_pkg::BASE_MOD4;
            n_mod100 = es2y_pkg::BASE_MOD100;
            n_cent4  = es2y_pkg::BASE_CENT4;
        end else if (i_step) begin
            // year field wraps modulo 4096; leap tracking keeps the true year
            n_year = r_year + 1'b1;
            n_mod4 = r_mod4 + 1'b1;
            if (r_mod100 == es2y_pkg::LAST_MOD100) begin
                n_mod100 = '0;
                n_cent4  = r_cent4 + 1'b1;
            end else begin
                n_mod100 = r_mod100 + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_year   <= n_year;
        r_mod4   <= n_mod4;
        r_mod100 <= n_mod100;
        r_cent4  <= n_cent4;
    end

    assign w_leap = ((r_mod4 == 2'd0) && (r_mod100 != 7'd0)) ||
                    ((r_mod100 == 7'd0) && (r_cent4 == 2'd0));

    assign o_year     = r_year;
    assign o_year_len = w_leap ? es2y_pkg::DAYS_LEAP : es2y_pkg::DAYS_COMMON;

endmodule

>>> src/epoch_seconds_to_year_day_time_core.sv
// ----------------------------------------------------------------------------
// epoch_seconds_to_year_day_time_core
// Converts seconds since the 1970 epoch to UTC year, day of year and time.
// ----------------------------------------------------------------------------
// Sequence: the shared multiplier splits days, hours and minutes by reciprocal
//   products, then the compare-subtract unit walks one year per cycle.
// One conversion at a time: start is taken only when idle, again in the o_strobe cycle.
// Reset: synchronous active-low; clears the sequencer and the strobe.
// Results show for one cycle on o_strobe; the receiver cannot stall.
module epoch_seconds_to_year_day_time_core #(
    parameter int unsigned SECONDS_WIDTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [SECONDS_WIDTH-1:0]        i_epoch_seconds,
    output logic                            o_strobe,
    output logic [es2y_pkg::YEAR_W-1:0]     o_year,
    output logic [es2y_pkg::DOY_W-1:0]      o_day_of_year,
    output logic [4:0]                      o_hour,
    output logic [5:0]                      o_minute,
    output logic [5:0]                      o_second
);

    localparam int unsigned NQ_W    = SECONDS_WIDTH - es2y_pkg::DAY_SHIFT;
    localparam int unsigned DAYS_W  = SECONDS_WIDTH - 16;
    localparam int unsigned MB_W    = es2y_pkg::MUL_B_W;
    localparam int unsigned PROD_W  = NQ_W + MB_W;
    localparam int unsigned DAY_K   = NQ_W + es2y_pkg::DAY_DIV_LOG;
    localparam int unsigned DAY_SEL = DAY_K - MB_W;
    localparam longint unsigned DAY_RECIP =
        ((64'd1 << DAY_K) + 64'(es2y_pkg::DAY_DIV) - 64'd1) / 64'(es2y_pkg::DAY_DIV);
    localparam logic [MB_W-1:0] DAY_RECIP_LO = MB_W'(DAY_RECIP);
    localparam logic [MB_W-1:0] DAY_RECIP_HI = MB_W'(DAY_RECIP >> MB_W);

    es2y_pkg::t_state r_state, n_state;

    logic [SECONDS_WIDTH-1:0]          r_num, n_num;
    logic [NQ_W-1:0]                   r_acc, n_acc;
    logic [es2y_pkg::TOD_W-1:0]        r_tod, n_tod;
    logic [DAYS_W-1:0]                 r_days, n_days;
    logic [4:0]                        r_hour, n_hour;
    logic [5:0]                        r_min, n_min;
    logic [5:0]                        r_sec, n_sec;
    logic [es2y_pkg::DOY_W-1:0]        r_doy, n_doy;
    logic                              r_strobe, n_strobe;

    logic [NQ_W-1:0]                   w_mul_a;
    logic [MB_W-1:0]                   w_mul_b;
    logic [PROD_W-1:0]                 w_prod;
    logic [PROD_W:0]                   w_day_sum;
    logic [es2y_pkg::TOD_W-1:0]        w_tod;
    logic [es2y_pkg::HREM_W-1:0]       w_hrem;
    logic [5:0]                        w_sec;
    logic [DAYS_W-1:0]                 w_diff;
    logic                              w_ge;
    logic                              w_year_load, w_year_step;
    logic [es2y_pkg::YEAR_W-1:0]       w_year;
    logic [es2y_pkg::DOY_W-1:0]        w_year_len;

    es2y_cmpsub #(
        .WIDTH (DAYS_W)
    ) u_cmpsub (
        .i_a    (r_days),
        .i_b    (DAYS_W'(w_year_len)),
        .o_diff (w_diff),
        .o_ge   (w_ge)
    );

    es2y_year u_year (
        .i_clk      (i_clk),
        .i_load     (w_year_load),
        .i_step     (w_year_step),
        .o_year     (w_year),
        .o_year_len (w_year_len)
    );

    // Shared multiplier: reciprocal quotients and quotient-times-divisor products
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            es2y_pkg::S_DAY_LO: begin
                w_mul_a = r_num[SECONDS_WIDTH-1:es2y_pkg::DAY_SHIFT];
                w_mul_b = DAY_RECIP_LO;
            end
            es2y_pkg::S_DAY_HI: begin
                w_mul_a = r_num[SECONDS_WIDTH-1:es2y_pkg::DAY_SHIFT];
                w_mul_b = DAY_RECIP_HI;
            end
            es2y_pkg::S_TOD: begin
                w_mul_a = NQ_W'(r_days);
                w_mul_b = MB_W'(es2y_pkg::SECS_PER_DAY);
            end
            es2y_pkg::S_HOUR_Q: begin
                w_mul_a = NQ_W'(r_tod[es2y_pkg::TOD_W-1:es2y_pkg::HOUR_PRE_SH]);
                w_mul_b = MB_W'(es2y_pkg::HOUR_RECIP);
            end
            es2y_pkg::S_HOUR_R: begin
                w_mul_a = NQ_W'(r_hour);
                w_mul_b = MB_W'(es2y_pkg::SECS_PER_HOUR);
            end
            es2y_pkg::S_MIN_Q: begin
                w_mul_a = NQ_W'(r_tod[es2y_pkg::HREM_W-1:es2y_pkg::MIN_PRE_SH]);
                w_mul_b = MB_W'(es2y_pkg::MIN_RECIP);
            end
            es2y_pkg::S_MIN_R: begin
                w_mul_a = NQ_W'(r_min);
                w_mul_b = MB_W'(es2y_pkg::SECS_PER_MIN);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod    = w_mul_a * w_mul_b;
    // high partial product plus the carried-down low partial product
    assign w_day_sum = {1'b0, w_prod} + (PROD_W + 1)'(r_acc);
    // remainders are below their modulus, so low-bit subtracts are exact
    assign w_tod     = r_num[es2y_pkg::TOD_W-1:0] - w_prod[es2y_pkg::TOD_W-1:0];
    assign w_hrem    = r_tod[es2y_pkg::HREM_W-1:0] - w_prod[es2y_pkg::HREM_W-1:0];
    assign w_sec     = r_tod[5:0] - w_prod[5:0];

    always_comb begin
        n_state     = r_state;
        n_num       = r_num;
        n_acc       = r_acc;
        n_tod       = r_tod;
        n_days      = r_days;
        n_hour      = r_hour;
        n_min       = r_min;
        n_sec       = r_sec;
        n_doy       = r_doy;
        n_strobe    = 1'b0;
        w_year_load = 1'b0;
        w_year_step = 1'b0;
        case (r_state)
            es2y_pkg::S_IDLE: begin
                if (start) begin
                    n_num       = i_epoch_seconds;
                    w_year_load = 1'b1;
                    n_state     = es2y_pkg::S_DAY_LO;
                end
            end
            es2y_pkg::S_DAY_LO: begin
                n_acc   = w_prod[PROD_W-1:MB_W];
                n_state = es2y_pkg::S_DAY_HI;
            end
            es2y_pkg::S_DAY_HI: begin
                n_days  = w_day_sum[DAY_SEL +: DAYS_W];
                n_state = es2y_pkg::S_TOD;
            end
            es2y_pkg::S_TOD: begin
                n_tod   = w_tod;
                n_state = es2y_pkg::S_HOUR_Q;
            end
            es2y_pkg::S_HOUR_Q: begin
                n_hour  = w_prod[es2y_pkg::HOUR_RECIP_SH +: 5];
                n_state = es2y_pkg::S_HOUR_R;
            end
            es2y_pkg::S_HOUR_R: begin
                n_tod   = es2y_pkg::TOD_W'(w_hrem);
                n_state = es2y_pkg::S_MIN_Q;
            end
            es2y_pkg::S_MIN_Q: begin
                n_min   = w_prod[es2y_pkg::MIN_RECIP_SH +: 6];
                n_state = es2y_pkg::S_MIN_R;
            end
            es2y_pkg::S_MIN_R: begin
                n_sec   = w_sec;
                n_state = es2y_pkg::S_YEAR;
            end
            es2y_pkg::S_YEAR: begin
                if (w_ge) begin
                    n_days      = w_diff;
                    w_year_step = 1'b1;
                end else begin
                    n_doy    = r_days[es2y_pkg::DOY_W-1:0] + 1'b1;
                    n_strobe = 1'b1;
                    n_state  = es2y_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = es2y_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= es2y_pkg::S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num  <= n_num;
        r_acc  <= n_acc;
        r_tod  <= n_tod;
        r_days <= n_days;
        r_hour <= n_hour;
        r_min  <= n_min;
        r_sec  <= n_sec;
        r_doy  <= n_doy;
    end

    assign busy          = (r_state != es2y_pkg::S_IDLE);
    assign o_strobe      = r_strobe;
    assign o_year        = w_year;
    assign o_day_of_year = r_doy;
    assign o_hour        = r_hour;
    assign o_minute      = r_min;
    assign o_second      = r_sec;

endmodule
